### hw/rtl/toy_cpu_load_store_stack_step_core_macros.svh
// Assertion macros shared by the toy CPU step core.
`ifndef TOY_CPU_LOAD_STORE_STACK_STEP_CORE_MACROS_SVH
`define TOY_CPU_LOAD_STORE_STACK_STEP_CORE_MACROS_SVH

// cond must hold at every edge out of reset
`define TCLS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define TCLS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/tcls_pkg.sv
// Shared constants, codes and types of the toy CPU step core.
package tcls_pkg;

   localparam int MEM_BYTES_DEF = 1024;
   localparam int DATA_BASE_DEF = 384;
   localparam int CODE_BASE_DEF = 128;
   localparam int NUM_GPRS_DEF  = 32;

   localparam int BANKS = 4;

   localparam logic [7:0] IDX_BP = 8'd32;
   localparam logic [7:0] IDX_SP = 8'd33;
   localparam logic [7:0] IDX_PC = 8'd34;

   localparam logic [7:0] OP_STORE = 8'd3;
   localparam logic [7:0] OP_LOAD  = 8'd4;
   localparam logic [7:0] OP_PUSH  = 8'd10;
   localparam logic [7:0] OP_POP   = 8'd11;

   localparam int          GPR_INIT_IDX = 5;
   localparam logic [31:0] GPR_INIT_VAL = 32'd10;
   localparam logic [31:0] WORD_BYTES   = 32'd4;

   typedef enum logic [1:0] {
      CMD_WBYTE = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_RREG  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_DECODE,
      ST_EXEC,
      ST_RREG,
      ST_RDONE,
      ST_SIMPLE
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic word_wr;
      logic byte_wr;
   } mem_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } gpr_ctl_type;

endpackage

### hw/rtl/tcls_if.sv
// Request and response channel interfaces of the toy CPU step core.
interface tcls_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [9:0] mem_address;
   logic [7:0] mem_byte;
   logic [5:0] reg_index;

   modport source (output valid, cmd, mem_address, mem_byte, reg_index, input ready);
   modport sink   (input valid, cmd, mem_address, mem_byte, reg_index, output ready);
endinterface

interface tcls_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  executed_opcode;
   logic [31:0] read_value;
   logic [31:0] pc_value;
   logic [31:0] sp_value;

   modport source (output valid, executed_opcode, read_value, pc_value, sp_value, input ready);
   modport sink   (input valid, executed_opcode, read_value, pc_value, sp_value, output ready);
endinterface

### hw/rtl/tcls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tcls_mem.sv
// Byte-banked main memory: unaligned little-endian word reads and writes, byte writes.
module tcls_mem #(
   parameter int MEM_BYTES = tcls_pkg::MEM_BYTES_DEF,
   localparam int ADDR_W   = $clog2(MEM_BYTES)
) (
   input  logic                  clock,
   input  tcls_pkg::mem_ctl_type ctl,
   input  logic [ADDR_W-1:0]     rd_addr,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [31:0]           wr_data,
   output logic [31:0]           rd_word
);

   localparam int ROWS = MEM_BYTES / tcls_pkg::BANKS;

   logic [1:0] rd_lo_ff;
   logic [7:0] bank_q [tcls_pkg::BANKS];

   // byte i of a word lives in bank (addr + i) mod 4; MEM_BYTES is a power of two
   for (genvar b = 0; b < tcls_pkg::BANKS; b++) begin : g_bank
      logic [1:0]        rd_off;
      logic [1:0]        wr_off;
      logic [ADDR_W-1:0] rd_byte_addr;
      logic [ADDR_W-1:0] wr_byte_addr;
      logic              we;
      logic [7:0]        wd;

      assign rd_off       = 2'(b) - rd_addr[1:0];
      assign wr_off       = 2'(b) - wr_addr[1:0];
      assign rd_byte_addr = rd_addr + ADDR_W'(rd_off);
      assign wr_byte_addr = wr_addr + ADDR_W'(wr_off);
      assign we           = ctl.word_wr || (ctl.byte_wr && (wr_addr[1:0] == 2'(b)));
      assign wd           = wr_data[{wr_off, 3'b000} +: 8];

      tcls_ram #(
         .WIDTH (8),
         .DEPTH (ROWS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (wr_byte_addr[ADDR_W-1:2]),
         .wr_data (wd),
         .rd_en   (ctl.rd_en),
         .rd_addr (rd_byte_addr[ADDR_W-1:2]),
         .rd_data (bank_q[b])
      );
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_lo_ff <= rd_addr[1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < tcls_pkg::BANKS; i++) begin
         rd_word[8*i +: 8] = bank_q[2'(rd_lo_ff + 2'(i))];
      end
   end

endmodule

### hw/rtl/tcls_gpr.sv
// General register file: RAM plus per-entry valid bits that supply the reset values.
module tcls_gpr #(
   parameter int NUM_GPRS = tcls_pkg::NUM_GPRS_DEF,
   localparam int GW      = $clog2(NUM_GPRS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tcls_pkg::gpr_ctl_type ctl,
   input  logic [GW-1:0]         rd_addr,
   input  logic [GW-1:0]         wr_addr,
   input  logic [31:0]           wr_data,
   output logic [31:0]           rd_value
);

   logic [NUM_GPRS-1:0] vld_ff;
   logic                rd_vld_ff;
   logic                rd_init_ff;
   logic [31:0]         ram_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_vld_ff  <= vld_ff[rd_addr];
         rd_init_ff <= (rd_addr == GW'(tcls_pkg::GPR_INIT_IDX));
      end
   end

   tcls_ram #(
      .WIDTH (32),
      .DEPTH (NUM_GPRS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rd_value = rd_vld_ff ? ram_q : (rd_init_ff ? tcls_pkg::GPR_INIT_VAL : 32'd0);

endmodule

### hw/rtl/toy_cpu_load_store_stack_step_core.sv
// Toy load/store/stack CPU core: one beat in writes a memory byte, executes one
// instruction or reads a register, and gives exactly one beat out. Main memory
// is four byte-wide banks (MEM_BYTES must be a power of two) and the general
// registers sit in a small RAM; bp, sp and pc are flops. Steps per beat: an
// instruction goes through fetch read, data/register read and write back, a
// register read through a register RAM read and its result, and a byte write or
// an unused cmd straight to its result. The next beat is taken in the last cycle
// of the current one as long as the output register is free or being drained.
// After reset the memory is cleared one row of four bytes per cycle, and no
// request is accepted until the clear is done.
`include "toy_cpu_load_store_stack_step_core_macros.svh"

module toy_cpu_load_store_stack_step_core #(
   parameter int MEM_BYTES = tcls_pkg::MEM_BYTES_DEF,
   parameter int DATA_BASE = tcls_pkg::DATA_BASE_DEF,
   parameter int CODE_BASE = tcls_pkg::CODE_BASE_DEF,
   parameter int NUM_GPRS  = tcls_pkg::NUM_GPRS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tcls_req_if.sink   req_ch,
   tcls_rsp_if.source rsp_ch
);

   localparam int ADDR_W = $clog2(MEM_BYTES);
   localparam int ROW_W  = ADDR_W - 2;
   localparam int GW     = $clog2(NUM_GPRS);

   localparam logic [ADDR_W-1:0] DATA_BASE_A = ADDR_W'(DATA_BASE);
   localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(MEM_BYTES / 4 - 1);
   localparam logic [7:0]        GPR_LIMIT   = 8'(NUM_GPRS);

   tcls_pkg::state_type state_ff, state_in, start_state;
   logic [ROW_W-1:0]    clr_cnt_ff, clr_cnt_in;

   tcls_pkg::cmd_type   cmd_ff;
   logic [ADDR_W-1:0]   maddr_ff;
   logic [7:0]          mbyte_ff;
   logic [7:0]          idx_ff;
   logic [7:0]          op_ff;
   logic [7:0]          dst_ff;
   logic [ADDR_W-1:0]   daddr_ff;

   logic [31:0]         bp_ff, bp_in;
   logic [31:0]         sp_ff, sp_in;
   logic [31:0]         pc_ff, pc_in;

   logic                rsp_vld_ff, rsp_vld_in;
   logic [7:0]          rsp_op_ff, rsp_op_in;
   logic [31:0]         rsp_rval_ff, rsp_rval_in;
   logic [31:0]         rsp_pc_ff;
   logic [31:0]         rsp_sp_ff;

   tcls_pkg::mem_ctl_type mem_ctl;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [31:0]           mem_wr_data;
   logic [31:0]           mem_rd_word;

   tcls_pkg::gpr_ctl_type gpr_ctl;
   logic [GW-1:0]         gpr_rd_addr;
   logic [GW-1:0]         gpr_wr_addr;
   logic [31:0]           gpr_val;

   logic        accept;
   logic        slot_free;
   logic        done;
   logic [7:0]  f_op;
   logic [7:0]  f_src;
   logic [7:0]  f_dst;
   logic [31:0] sp_dec;
   logic [ADDR_W-1:0] dec_addr;
   logic [31:0] src_val;
   logic        is_ld;
   logic        is_st;
   logic [31:0] sp_base;

   tcls_mem #(
      .MEM_BYTES (MEM_BYTES)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_word (mem_rd_word)
   );

   tcls_gpr #(
      .NUM_GPRS (NUM_GPRS)
   ) u_gpr (
      .clock    (clock),
      .reset    (reset),
      .ctl      (gpr_ctl),
      .rd_addr  (gpr_rd_addr),
      .wr_addr  (gpr_wr_addr),
      .wr_data  (mem_rd_word),
      .rd_value (gpr_val)
   );

   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_vld_ff || rsp_ch.ready;

   assign f_op   = mem_rd_word[7:0];
   assign f_src  = mem_rd_word[15:8];
   assign f_dst  = mem_rd_word[23:16];
   assign sp_dec = sp_ff - tcls_pkg::WORD_BYTES;

   assign is_ld = (op_ff == tcls_pkg::OP_LOAD) || (op_ff == tcls_pkg::OP_POP);
   assign is_st = (op_ff == tcls_pkg::OP_STORE) || (op_ff == tcls_pkg::OP_PUSH);

   always_comb begin
      case (f_op)
         tcls_pkg::OP_LOAD:  dec_addr = DATA_BASE_A + ADDR_W'(f_src);
         tcls_pkg::OP_STORE: dec_addr = DATA_BASE_A + ADDR_W'(f_dst);
         tcls_pkg::OP_PUSH:  dec_addr = sp_dec[ADDR_W-1:0];
         default:            dec_addr = sp_ff[ADDR_W-1:0];
      endcase
   end

   // register operand; pc reads as the current instruction address
   always_comb begin
      if (idx_ff < GPR_LIMIT) begin
         src_val = gpr_val;
      end else if (idx_ff == tcls_pkg::IDX_BP) begin
         src_val = bp_ff;
      end else if (idx_ff == tcls_pkg::IDX_SP) begin
         src_val = sp_ff;
      end else if (idx_ff == tcls_pkg::IDX_PC) begin
         src_val = pc_ff;
      end else begin
         src_val = 32'd0;
      end
   end

   always_comb begin
      case (tcls_pkg::cmd_type'(req_ch.cmd))
         tcls_pkg::CMD_STEP: start_state = tcls_pkg::ST_FETCH;
         tcls_pkg::CMD_RREG: start_state = tcls_pkg::ST_RREG;
         default:            start_state = tcls_pkg::ST_SIMPLE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcls_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == LAST_ROW) begin
               state_in = tcls_pkg::ST_IDLE;
            end
         end
         tcls_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = start_state;
            end
         end
         tcls_pkg::ST_FETCH:  state_in = tcls_pkg::ST_DECODE;
         tcls_pkg::ST_DECODE: state_in = tcls_pkg::ST_EXEC;
         tcls_pkg::ST_RREG:   state_in = tcls_pkg::ST_RDONE;
         tcls_pkg::ST_EXEC, tcls_pkg::ST_RDONE, tcls_pkg::ST_SIMPLE: begin
            if (done) begin
               state_in = accept ? start_state : tcls_pkg::ST_IDLE;
            end
         end
         default: state_in = tcls_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      mem_ctl     = '0;
      mem_rd_addr = pc_ff[ADDR_W-1:0];
      mem_wr_addr = daddr_ff;
      mem_wr_data = src_val;
      gpr_ctl     = '0;
      gpr_rd_addr = idx_ff[GW-1:0];
      gpr_wr_addr = dst_ff[GW-1:0];
      done        = 1'b0;
      case (state_ff)
         tcls_pkg::ST_CLEAR: begin
            mem_ctl.word_wr = 1'b1;
            mem_wr_addr     = {clr_cnt_ff, 2'b00};
            mem_wr_data     = 32'd0;
         end
         tcls_pkg::ST_FETCH: begin
            mem_ctl.rd_en = 1'b1;
         end
         tcls_pkg::ST_DECODE: begin
            mem_ctl.rd_en = (f_op == tcls_pkg::OP_LOAD) || (f_op == tcls_pkg::OP_POP);
            mem_rd_addr   = dec_addr;
            gpr_ctl.rd_en = f_src < GPR_LIMIT;
            gpr_rd_addr   = f_src[GW-1:0];
         end
         tcls_pkg::ST_RREG: begin
            gpr_ctl.rd_en = idx_ff < GPR_LIMIT;
         end
         tcls_pkg::ST_EXEC: begin
            done            = slot_free;
            mem_ctl.word_wr = slot_free && is_st;
            gpr_ctl.wr_en   = slot_free && is_ld && (dst_ff < GPR_LIMIT);
         end
         tcls_pkg::ST_RDONE: begin
            done = slot_free;
         end
         tcls_pkg::ST_SIMPLE: begin
            done            = slot_free;
            mem_ctl.byte_wr = slot_free && (cmd_ff == tcls_pkg::CMD_WBYTE);
            mem_wr_addr     = maddr_ff;
            mem_wr_data     = {24'd0, mbyte_ff};
         end
         default: ;
      endcase
   end

   assign req_ch.ready = (state_ff == tcls_pkg::ST_IDLE) || done;

   // architectural pointers and result beat
   always_comb begin
      bp_in   = bp_ff;
      sp_in   = sp_ff;
      pc_in   = pc_ff;
      sp_base = sp_ff;
      if (state_ff == tcls_pkg::ST_EXEC) begin
         if (is_ld && (dst_ff == tcls_pkg::IDX_BP)) begin
            bp_in = mem_rd_word;
         end
         if (is_ld && (dst_ff == tcls_pkg::IDX_SP)) begin
            sp_base = mem_rd_word;
         end
         if (op_ff == tcls_pkg::OP_POP) begin
            sp_in = sp_base + tcls_pkg::WORD_BYTES;
         end else if (op_ff == tcls_pkg::OP_PUSH) begin
            sp_in = sp_dec;
         end else begin
            sp_in = sp_base;
         end
         pc_in = ((is_ld && (dst_ff == tcls_pkg::IDX_PC)) ? mem_rd_word : pc_ff)
                 + tcls_pkg::WORD_BYTES;
      end
      rsp_op_in   = (state_ff == tcls_pkg::ST_EXEC) ? op_ff : 8'd0;
      rsp_rval_in = (state_ff == tcls_pkg::ST_RDONE) ? src_val : 32'd0;
      rsp_vld_in  = done || (rsp_vld_ff && !rsp_ch.ready);
      clr_cnt_in  = clr_cnt_ff + ROW_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tcls_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
         bp_ff      <= 32'd0;
         sp_ff      <= 32'(MEM_BYTES);
         pc_ff      <= 32'(CODE_BASE);
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         if (state_ff == tcls_pkg::ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_in;
         end
         if (done) begin
            bp_ff <= bp_in;
            sp_ff <= sp_in;
            pc_ff <= pc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= tcls_pkg::cmd_type'(req_ch.cmd);
         maddr_ff <= ADDR_W'(req_ch.mem_address);
         mbyte_ff <= req_ch.mem_byte;
         idx_ff   <= {2'b00, req_ch.reg_index};
      end
      if (state_ff == tcls_pkg::ST_DECODE) begin
         op_ff    <= f_op;
         dst_ff   <= f_dst;
         idx_ff   <= f_src;
         daddr_ff <= dec_addr;
      end
      if (done) begin
         rsp_op_ff   <= rsp_op_in;
         rsp_rval_ff <= rsp_rval_in;
         rsp_pc_ff   <= pc_in;
         rsp_sp_ff   <= sp_in;
      end
   end

   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.executed_opcode = rsp_op_ff;
   assign rsp_ch.read_value      = rsp_rval_ff;
   assign rsp_ch.pc_value        = rsp_pc_ff;
   assign rsp_ch.sp_value        = rsp_sp_ff;

   `TCLS_ASSERT_ALWAYS(a_no_rw_clash, !(mem_ctl.rd_en && (mem_ctl.word_wr || mem_ctl.byte_wr)), "memory read issued in a write cycle")
   `TCLS_ASSERT_IMPLIES(a_no_accept_clear, state_ff == tcls_pkg::ST_CLEAR, !req_ch.ready, "request taken during clear")
   `TCLS_ASSERT_NEXT(a_step_fetches, accept && (req_ch.cmd == tcls_pkg::CMD_STEP), state_ff == tcls_pkg::ST_FETCH, "step did not start with fetch")
   `TCLS_ASSERT_NEXT(a_done_gives_beat, done, rsp_vld_ff, "finished item gave no response beat")

endmodule
